// File: src/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types, sizes and codes for the set-step automaton matcher.
// ----------------------------------------------------------------------------
package nss_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_SYMBOLS = 8;

	localparam int SYM_IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

	// Fixed field widths of the item, result and configuration words.
	localparam int ACTION_W   = 2;
	localparam int FROM_W     = 4;
	localparam int SYMBOL_W   = 3;
	localparam int MASK_W     = 16;
	localparam int ALPHABET_W = 4;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	typedef logic [NUM_STATES-1:0] state_mask_t;
	typedef logic [SYM_IDX_W-1:0]  sym_idx_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_CONSUME = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef enum logic {
		REG_ACCEPT_MASK   = 1'b0,
		REG_ALPHABET_SIZE = 1'b1
	} reg_idx_t;

	localparam logic [ALPHABET_W-1:0] ALPHABET_RESET = 4'd8;

	typedef struct packed {
		logic [MASK_W-1:0]     accept_mask;
		logic [ALPHABET_W-1:0] alphabet_size;
	} cfg_t;

	// Shared by every cell of the row: which table column to use this cycle
	// and the row written by a load word.
	typedef struct packed {
		sym_idx_t    sym_idx;
		state_mask_t wr_data;
	} cell_ctrl_t;

	function automatic state_mask_t to_state_mask(input logic [MASK_W-1:0] m);
		state_mask_t r;
		r = '0;
		for (int i = 0; i < NUM_STATES && i < MASK_W; i++) begin
			r[i] = m[i];
		end
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] to_field_mask(input state_mask_t s);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int i = 0; i < NUM_STATES && i < MASK_W; i++) begin
			r[i] = s[i];
		end
		return r;
	endfunction

endpackage

// File: src/nss_if.sv
// ----------------------------------------------------------------------------
// nss item and result channels
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface nss_item_if;
	import nss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [FROM_W-1:0]     from_state;
	logic [SYMBOL_W-1:0]   symbol;
	logic [MASK_W-1:0]     next_mask;

	modport source (output valid, action, from_state, symbol, next_mask, input ready);
	modport sink   (input valid, action, from_state, symbol, next_mask, output ready);
endinterface

interface nss_result_if;
	import nss_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] active_mask;
	logic              accepted;
	logic              rejected;

	modport source (output valid, active_mask, accepted, rejected, input ready);
	modport sink   (input valid, active_mask, accepted, rejected, output ready);
endinterface

// File: src/nss_cfg_regs.sv
// ----------------------------------------------------------------------------
// nss_cfg_regs
// APB register file holding the accepting mask and the alphabet size.
// ----------------------------------------------------------------------------
module nss_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nss_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nss_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nss_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output nss_pkg::cfg_t                  cfg
);
	import nss_pkg::*;

	logic [MASK_W-1:0]     accept_mask_q;
	logic [ALPHABET_W-1:0] alphabet_size_q;
	logic                  wr_en;
	reg_idx_t              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_mask_q   <= '0;
			alphabet_size_q <= ALPHABET_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ACCEPT_MASK:   accept_mask_q   <= pwdata[MASK_W-1:0];
				REG_ALPHABET_SIZE: alphabet_size_q <= pwdata[ALPHABET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACCEPT_MASK:   prdata = APB_DATA_W'(accept_mask_q);
			REG_ALPHABET_SIZE: prdata = APB_DATA_W'(alphabet_size_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.accept_mask   = accept_mask_q;
	assign cfg.alphabet_size = alphabet_size_q;

endmodule

// File: src/nss_cell.sv
// ----------------------------------------------------------------------------
// nss_cell
// One state of the automaton: its successor rows for every symbol, and one
// link of the OR chain that builds the next active set.
// ----------------------------------------------------------------------------
module nss_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nss_pkg::cell_ctrl_t  ctrl,
	input  logic                 wr_en,
	input  logic                 active,
	input  nss_pkg::state_mask_t acc_in,
	output nss_pkg::state_mask_t acc_out
);
	import nss_pkg::*;

	state_mask_t rows_q [NUM_SYMBOLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SYMBOLS; s++) begin
				rows_q[s] <= '0;
			end
		end else if (wr_en) begin
			rows_q[ctrl.sym_idx] <= ctrl.wr_data;
		end
	end

	// An active state contributes its row for the current symbol.
	assign acc_out = acc_in | (active ? rows_q[ctrl.sym_idx] : '0);

endmodule

// File: src/nfa_set_step_matcher.sv
// ----------------------------------------------------------------------------
// nfa_set_step_matcher
// Bit-parallel automaton simulation over a symbol stream, built as a row of
// per-state cells whose rows are ORed along the chain.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+-------------------------------------
//  item    | in        | valid/ready       | action, from_state, symbol, next_mask
//  result  | out       | valid/ready       | active_mask, accepted, rejected
//  apb     | in        | psel/penable/prdy | accept_mask (0x0), alphabet_size (0x4)
//
// One word is taken per cycle unless a result is stalled; its result is
// registered and shows in the cycle after acceptance. The OR chain through all
// state cells forms the next active set on acceptance and bounds the clock rate.
// While a result waits, a new word is still taken if result.ready is high.
// Reset clears the table to no transitions and leaves only state 0 active.
//
module nfa_set_step_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	nss_item_if.sink                       item,
	nss_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nss_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nss_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nss_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import nss_pkg::*;

	cfg_t        cfg;
	cell_ctrl_t  ctrl;
	state_mask_t chain [NUM_STATES+1];
	logic [NUM_STATES-1:0] wr_en;

	state_mask_t       active_q;
	state_mask_t       next_set;
	state_mask_t       accept_states;
	logic              take;
	logic              sym_ok;
	logic              wr_ok;
	action_t           action;

	logic              out_valid_q;
	logic [MASK_W-1:0] active_mask_q;
	logic              accepted_q;
	logic              rejected_q;

	nss_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item.ready = !out_valid_q || result.ready;
	assign take       = item.valid && item.ready;
	assign action     = action_t'(item.action);

	assign ctrl.sym_idx = SYM_IDX_W'(item.symbol);
	assign ctrl.wr_data = to_state_mask(item.next_mask);

	assign wr_ok  = take && (action == ACT_WRITE) && (32'(item.symbol) < NUM_SYMBOLS);
	assign sym_ok = (32'(item.symbol) < 32'(cfg.alphabet_size))
	             && (32'(item.symbol) < NUM_SYMBOLS);

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_STATES; i++) begin : g_cell
		assign wr_en[i] = wr_ok && (32'(item.from_state) == i);

		nss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.wr_en   (wr_en[i]),
			.active  (active_q[i]),
			.acc_in  (chain[i]),
			.acc_out (chain[i+1])
		);
	end

	always_comb begin
		case (action)
			ACT_CONSUME: next_set = sym_ok ? chain[NUM_STATES] : '0;
			ACT_RESTART: next_set = state_mask_t'(1);
			default:     next_set = active_q;
		endcase
	end

	assign accept_states = to_state_mask(cfg.accept_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= state_mask_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q    <= next_set;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			active_mask_q <= to_field_mask(next_set);
			accepted_q    <= |(next_set & accept_states);
			rejected_q    <= ~|next_set;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.active_mask = active_mask_q;
	assign result.accepted    = accepted_q;
	assign result.rejected    = rejected_q;

endmodule

// File: src/nss_checker.sv
// ----------------------------------------------------------------------------
// nss_checker
// Port-level checks for the set-step matcher, bound to the top level.
// ----------------------------------------------------------------------------
module nss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic [nss_pkg::ACTION_W-1:0] item_action,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [nss_pkg::MASK_W-1:0] result_active_mask,
	input logic                       result_accepted,
	input logic                       result_rejected
);
	import nss_pkg::*;

	logic item_take;

	assign item_take = item_valid && item_ready;

	// Every word taken yields a result word in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> result_valid)
		else $error("no result after an accepted word");

	// A restart leaves exactly the start state active.
	a_restart_set: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item_action == ACT_RESTART)
		|=> (result_active_mask == 16'd1 && !result_rejected))
		else $error("restart did not report the start state alone");

	// An empty set can neither accept nor be reported as nonempty.
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_rejected == (result_active_mask == '0))
		                 && !(result_rejected && result_accepted))
		else $error("accepted/rejected flags disagree with the active mask");

	// A stalled result word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready)
		|=> (result_valid && $stable(result_active_mask)
		     && $stable(result_accepted) && $stable(result_rejected)))
		else $error("stalled result word changed");

endmodule

bind nfa_set_step_matcher nss_checker u_nss_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.item_action        (item.action),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_active_mask (result.active_mask),
	.result_accepted    (result.accepted),
	.result_rejected    (result.rejected)
);
